// ----- hw/rtl/usp_pkg.sv -----
// shared types, codes and defaults for the uniform sum density/distribution unit
`default_nettype none
package usp_pkg;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // configuration register indexes
    localparam logic [1:0] REG_LOW_FIRST   = 2'd0;
    localparam logic [1:0] REG_HIGH_FIRST  = 2'd1;
    localparam logic [1:0] REG_LOW_SECOND  = 2'd2;
    localparam logic [1:0] REG_HIGH_SECOND = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    // mode selector
    localparam logic MODE_CDF = 1'b1;

    // segment of the piecewise curve
    typedef enum logic [2:0] {
        SEG_ZERO = 3'd0,
        SEG_ONE  = 3'd1,
        SEG_RISE = 3'd2,
        SEG_FLAT = 3'd3,
        SEG_FALL = 3'd4
    } seg_t;

    // per-item flags carried along the divider chain
    typedef struct packed {
        logic inval;
        logic fall;
        logic ovf;
    } flags_t;

endpackage
`default_nettype wire

// ----- hw/rtl/usp_prep.sv -----
// classification, products and numerator/denominator setup ahead of the divider
`default_nettype none
module usp_prep
    import usp_pkg::*;
#(
    parameter int W  = DEF_DATA_WIDTH,
    parameter int F  = DEF_FRAC_BITS,
    parameter int CW = 3 * DEF_DATA_WIDTH + 2 * DEF_FRAC_BITS + 2
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [W-1:0]  point,
    input  wire logic          mode,
    input  wire logic [W-1:0]  a1,
    input  wire logic [W-1:0]  b1,
    input  wire logic [W-1:0]  a2,
    input  wire logic [W-1:0]  b2,
    output logic               out_valid,
    output logic [CW-1:0]      out_rem,
    output logic [CW-1:0]      out_den,
    output flags_t             out_flags
);

    localparam int EW = W + 2;

    logic signed [EW-1:0] ea1, eb1, ea2, eb2, ex;
    logic signed [EW-1:0] a12, b12, s1, s2, lo, hi;
    logic                 inval;
    logic [W-1:0]         r1, r2, rmin, rmax, u, v;
    seg_t                 seg;

    assign ea1 = $signed({{2{a1[W-1]}}, a1});
    assign eb1 = $signed({{2{b1[W-1]}}, b1});
    assign ea2 = $signed({{2{a2[W-1]}}, a2});
    assign eb2 = $signed({{2{b2[W-1]}}, b2});
    assign ex  = $signed({{2{point[W-1]}}, point});

    assign a12 = ea1 + ea2;
    assign b12 = eb1 + eb2;
    assign s1  = ea1 + eb2;
    assign s2  = ea2 + eb1;
    assign lo  = (s1 < s2) ? s1 : s2;
    assign hi  = (s1 < s2) ? s2 : s1;
    assign inval = (eb1 <= ea1) || (eb2 <= ea2);

    assign r1   = W'(eb1 - ea1);
    assign r2   = W'(eb2 - ea2);
    assign rmin = (r1 < r2) ? r1 : r2;
    assign rmax = (r1 < r2) ? r2 : r1;
    assign u    = W'(ex - a12);
    assign v    = W'(b12 - ex);

    always_comb
    begin
        if (ex <= a12)
        begin
            seg = SEG_ZERO;
        end
        else if (ex >= b12)
        begin
            seg = SEG_ONE;
        end
        else if ((ex < lo) || ((s1 == s2) && (ex == lo)))
        begin
            seg = SEG_RISE;
        end
        else if (ex < hi)
        begin
            seg = SEG_FLAT;
        end
        else
        begin
            seg = SEG_FALL;
        end
    end

    // stage a: classification
    logic         a_valid_reg;
    seg_t         a_seg_reg;
    logic         a_cum_reg, a_inval_reg;
    logic [W-1:0] a_u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_seg_reg   <= seg;
            a_cum_reg   <= (mode == MODE_CDF);
            a_inval_reg <= inval;
            a_u_reg     <= (seg == SEG_FALL) ? v : u;
        end
    end

    // stage b: products
    logic            b_valid_reg;
    seg_t            b_seg_reg;
    logic            b_cum_reg, b_inval_reg;
    logic [W-1:0]    b_u_reg;
    logic [2*W-1:0]  b_prod_reg, b_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_seg_reg   <= a_seg_reg;
            b_cum_reg   <= a_cum_reg;
            b_inval_reg <= a_inval_reg;
            b_u_reg     <= a_u_reg;
            b_prod_reg  <= (2*W)'(r1) * (2*W)'(r2);
            b_sq_reg    <= (2*W)'(a_u_reg) * (2*W)'(a_u_reg);
        end
    end

    // stage c: dividend and divisor
    logic [CW-1:0] num, den;
    logic          ovf;

    always_comb
    begin
        num = CW'(0);
        den = CW'(1);
        case (b_seg_reg)
            SEG_ONE:
            begin
                num = b_cum_reg ? (CW'(1) << F) : CW'(0);
            end
            SEG_RISE, SEG_FALL:
            begin
                if (b_cum_reg)
                begin
                    num = CW'(b_sq_reg) << F;
                    den = CW'(b_prod_reg) << 1;
                end
                else
                begin
                    num = CW'(b_u_reg) << (2 * F);
                    den = CW'(b_prod_reg);
                end
            end
            SEG_FLAT:
            begin
                if (b_cum_reg)
                begin
                    num = ((CW'(b_u_reg) << 1) - CW'(rmin)) << F;
                    den = CW'(rmax) << 1;
                end
                else
                begin
                    num = CW'(1) << (2 * F);
                    den = CW'(rmax);
                end
            end
            default:
            begin
                num = CW'(0);
                den = CW'(1);
            end
        endcase
        if (b_inval_reg)
        begin
            num = CW'(0);
            den = CW'(1);
        end
    end

    // quotient would need more than W bits
    assign ovf = (num >= (den << W));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rem         <= num;
            out_den         <= den;
            out_flags.inval <= b_inval_reg;
            out_flags.fall  <= (b_seg_reg == SEG_FALL) && b_cum_reg && !b_inval_reg;
            out_flags.ovf   <= ovf;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/usp_div_cell.sv -----
// one restoring division cell, resolves one quotient bit per item
`default_nettype none
module usp_div_cell
    import usp_pkg::*;
#(
    parameter int W     = DEF_DATA_WIDTH,
    parameter int CW    = 3 * DEF_DATA_WIDTH + 2 * DEF_FRAC_BITS + 2,
    parameter int SHIFT = 0
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [CW-1:0] in_rem,
    input  wire logic [CW-1:0] in_den,
    input  wire logic [W-1:0]  in_quo,
    input  wire flags_t        in_flags,
    output logic               out_valid,
    output logic [CW-1:0]      out_rem,
    output logic [CW-1:0]      out_den,
    output logic [W-1:0]       out_quo,
    output flags_t             out_flags
);

    logic [CW-1:0] trial;
    logic          take;
    logic [W-1:0]  quo_next;

    assign trial = in_den << SHIFT;
    assign take  = (in_rem >= trial);

    always_comb
    begin
        quo_next = in_quo;
        quo_next[SHIFT] = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rem   <= take ? (in_rem - trial) : in_rem;
            out_den   <= in_den;
            out_quo   <= quo_next;
            out_flags <= in_flags;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/uniform_sum_pdf_cdf_unit.sv -----
// top level: density / distribution of the sum of two uniforms, pipelined
`default_nettype none
// channel   dir  fields (low bit up)                  handshake
// s_        in   tdata: point, tuser: mode            s_tvalid/s_tready
// m_        out  tdata: value, tuser: status          m_tvalid/m_tready
// cfg_      in   cfg_index, cfg_data                  cfg_we, no wait
//
// one item per cycle while the pipeline is not held; the stages are three setup stages,
// one divider cell per quotient bit, then the output register
// the whole pipeline moves together; it holds only while a result sits in
// the output register and m_tready is low
// reset clears valid bits and loads the default bounds [0,1] and [0,1]
module uniform_sum_pdf_cdf_unit
    import usp_pkg::*;
#(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]   s_tdata,   // point
    input  wire logic                              s_tuser,   // mode
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_tdata,   // value
    output logic [1:0]                             m_tuser,   // status
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [DATA_WIDTH-1:0]             cfg_data
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int CW  = 3 * W + 2 * F + 2;
    localparam int RW  = W + F + 2;
    localparam int TDW = ((W + 7) / 8) * 8;

    // bound registers
    logic [W-1:0] a1_reg, b1_reg, a2_reg, b2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg <= '0;
            b1_reg <= W'(1) << F;
            a2_reg <= '0;
            b2_reg <= W'(1) << F;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_FIRST:   a1_reg <= cfg_data;
                REG_HIGH_FIRST:  b1_reg <= cfg_data;
                REG_LOW_SECOND:  a2_reg <= cfg_data;
                REG_HIGH_SECOND: b2_reg <= cfg_data;
                default:         a1_reg <= a1_reg;
            endcase
        end
    end

    // global advance: output register empty or being drained
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // divider chain, element 0 comes from setup
    logic          ch_valid [0:W];
    logic [CW-1:0] ch_rem   [0:W];
    logic [CW-1:0] ch_den   [0:W];
    logic [W-1:0]  ch_quo   [0:W];
    flags_t        ch_flags [0:W];

    assign ch_quo[0] = '0;

    usp_prep #(
        .W  (W),
        .F  (F),
        .CW (CW)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .point     (s_tdata[W-1:0]),
        .mode      (s_tuser),
        .a1        (a1_reg),
        .b1        (b1_reg),
        .a2        (a2_reg),
        .b2        (b2_reg),
        .out_valid (ch_valid[0]),
        .out_rem   (ch_rem[0]),
        .out_den   (ch_den[0]),
        .out_flags (ch_flags[0])
    );

    // msb-first: cell j resolves quotient bit W-1-j
    for (genvar j = 0; j < W; j++)
    begin : g_cell
        usp_div_cell #(
            .W     (W),
            .CW    (CW),
            .SHIFT (W - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (ch_valid[j]),
            .in_rem    (ch_rem[j]),
            .in_den    (ch_den[j]),
            .in_quo    (ch_quo[j]),
            .in_flags  (ch_flags[j]),
            .out_valid (ch_valid[j+1]),
            .out_rem   (ch_rem[j+1]),
            .out_den   (ch_den[j+1]),
            .out_quo   (ch_quo[j+1]),
            .out_flags (ch_flags[j+1])
        );
    end

    // falling cumulative segment: floor(1 - t) = one - ceil(t)
    logic          inexact;
    logic [RW-1:0] res;
    logic          sat;
    logic [W-1:0]  value_next;
    logic [1:0]    status_next;

    assign inexact = (ch_rem[W] != '0);

    always_comb
    begin
        if (ch_flags[W].fall)
        begin
            res = (RW'(1) << F) - RW'(ch_quo[W]) - RW'(inexact);
        end
        else
        begin
            res = RW'(ch_quo[W]);
        end
        sat = ch_flags[W].ovf || (res[RW-1:W] != '0);
        if (ch_flags[W].inval)
        begin
            value_next  = '0;
            status_next = ST_INVALID;
        end
        else if (sat)
        begin
            value_next  = '1;
            status_next = ST_SAT;
        end
        else
        begin
            value_next  = res[W-1:0];
            status_next = ST_OK;
        end
    end

    // output register
    logic [W-1:0] value_reg;
    logic [1:0]   status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid <= ch_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign m_tdata = TDW'(value_reg);
    assign m_tuser = status_reg;

endmodule
`default_nettype wire

// ----- tb/sv/uniform_sum_checker.sv -----
// checker for the uniform sum unit: predicts each result and compares it
module uniform_sum_checker
    import usp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // point
    input  wire logic        s_tuser,   // mode
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // value
    input  wire logic [1:0]  m_tuser,   // status
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               checked
);

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } outcome_t;

    localparam logic [127:0] ONE_Q = 128'd65536;
    localparam logic [127:0] VMAX  = 128'hFFFF_FFFF;

    outcome_t    want_q[$];
    longint      lo1, hi1, lo2, hi2;

    function automatic outcome_t saturate(logic [127:0] q);
        outcome_t o;
        if (q > VMAX)
        begin
            o.value  = 32'hFFFF_FFFF;
            o.status = ST_SAT;
        end
        else
        begin
            o.value  = q[31:0];
            o.status = ST_OK;
        end
        return o;
    endfunction

    // exact value floored to 16 fraction bits
    function automatic outcome_t trapezoid_eval(logic [31:0] pt, logic md);
        outcome_t     o;
        longint       x, a12, b12, s1, s2, lo, hi;
        logic [127:0] r1, r2, rmin, rmax, prod, u, num, den, q;
        x   = longint'(signed'(pt));
        a12 = lo1 + lo2;
        b12 = hi1 + hi2;
        s1  = lo1 + hi2;
        s2  = lo2 + hi1;
        if (hi1 <= lo1 || hi2 <= lo2)
        begin
            o.value  = '0;
            o.status = ST_INVALID;
            return o;
        end
        if (x <= a12)
        begin
            o.value  = '0;
            o.status = ST_OK;
            return o;
        end
        if (x >= b12)
            return saturate(md == MODE_CDF ? ONE_Q : 128'd0);
        r1   = 128'(hi1 - lo1);
        r2   = 128'(hi2 - lo2);
        rmin = r1 < r2 ? r1 : r2;
        rmax = r1 < r2 ? r2 : r1;
        lo   = s1 < s2 ? s1 : s2;
        hi   = s1 < s2 ? s2 : s1;
        prod = r1 * r2;
        if (x < lo || (s1 == s2 && x == lo))
        begin
            // rising edge of the trapezoid
            u = 128'(x - a12);
            if (md != MODE_CDF)
                q = (u << 32) / prod;
            else
                q = ((u * u) << 16) / (prod << 1);
        end
        else if (x < hi)
        begin
            // flat top
            u = 128'(x - a12);
            if (md != MODE_CDF)
                q = (128'd1 << 32) / rmax;
            else
                q = ((2 * u - rmin) << 16) / (2 * rmax);
        end
        else
        begin
            // falling edge, distribution is one minus the ceiling of the tail
            u = 128'(b12 - x);
            if (md != MODE_CDF)
                q = (u << 32) / prod;
            else
            begin
                num = (u * u) << 16;
                den = prod << 1;
                q   = num / den;
                q   = ONE_Q - q - ((num % den) != 0 ? 128'd1 : 128'd0);
            end
        end
        return saturate(q);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            lo1     <= 0;
            hi1     <= 65536;
            lo2     <= 0;
            hi2     <= 65536;
            errors  <= 0;
            checked <= 0;
            pending <= 0;
            want_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOW_FIRST:   lo1 <= longint'(signed'(cfg_data));
                    REG_HIGH_FIRST:  hi1 <= longint'(signed'(cfg_data));
                    REG_LOW_SECOND:  lo2 <= longint'(signed'(cfg_data));
                    REG_HIGH_SECOND: hi2 <= longint'(signed'(cfg_data));
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
                want_q.push_back(trapezoid_eval(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                checked <= checked + 1;
                if (want_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result value=%h status=%0d", m_tdata, m_tuser);
                    errors <= errors + 1;
                end
                else
                begin
                    want = want_q.pop_front();
                    if (want.value !== m_tdata || want.status !== m_tuser)
                    begin
                        if (errors < 10)
                            $display("result %0d: expected value=%h status=%0d, got value=%h status=%0d",
                                     checked, want.value, want.status, m_tdata, m_tuser);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= want_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_uniform_sum_pdf_cdf_unit.sv -----
// testbench top: stimulus and verdict for the uniform sum unit
module tb_uniform_sum_pdf_cdf_unit;
    import usp_pkg::*;

    localparam int LATENCY   = 36;
    localparam int MAX_CYCLE = 400000;
    localparam int NSETS     = 9;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // point
    logic        s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // value
    logic [1:0]  m_tuser;   // status
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int          errors, pending, checked;
    int          cycles;
    int          sent;
    bit          idle_on;

    // bound sets: a1, b1, a2, b2 in raw Q16.16
    longint      bounds [NSETS][4] = '{
        '{0, 65536, 0, 65536},                       // default triangle
        '{0, 131072, 65536, 262144},                 // trapezoid, ranges 2 and 3
        '{-196608, -65536, -32768, 98304},           // negative bounds
        '{0, 1, 0, 3},                               // tiny ranges, large density
        '{-2147483648, 2147483647, -2147483648, 2147483647}, // full span both
        '{5, 5, 0, 1},                               // empty first range
        '{0, 1, 7, 3},                               // reversed second range
        '{100, 1000, -50, 37},                       // odd small ranges, inexact tails
        '{2147483646, 2147483647, -2147483648, 0}    // one tiny, one wide
    };
    longint      cur [4];

    uniform_sum_pdf_cdf_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    uniform_sum_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver stalls about a third of the cycles while idling is on
    always @(posedge clk)
    begin
        if (idle_on)
            m_tready <= ($urandom_range(99) >= 33);
        else
            m_tready <= 1'b1;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > MAX_CYCLE)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // one item; valid stays high across back-to-back items
    task automatic send_point(longint pt, logic md);
        // each cycle idles with a chance of about a third
        if (idle_on)
        begin
            while ($urandom_range(99) < 33)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 32'(pt);
        s_tuser  <= md;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // bounds are only changed with the pipeline empty
    task automatic load_bounds(longint b0, longint b1, longint b2, longint b3);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cur = '{b0, b1, b2, b3};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= 32'(cur[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // random point, mostly inside the support with a margin on each side
    function automatic longint pick_point();
        longint a12, b12, span;
        logic [63:0] r;
        a12 = cur[0] + cur[2];
        b12 = cur[1] + cur[3];
        r   = {$urandom, $urandom};
        if ($urandom_range(99) < 15 || b12 <= a12)
            return longint'(signed'(r[31:0]));
        span = b12 - a12 + 5;
        return clamp32(a12 - 2 + longint'(r % 64'(span)));
    endfunction

    initial
    begin
        longint a12, b12, s1, s2;
        longint pts [10];
        int     setsel;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b1;
        cfg_we    = 1'b0;
        cfg_index = REG_LOW_FIRST;
        cfg_data  = '0;
        idle_on   = 1'b0;
        sent      = 0;
        cur       = '{0, 65536, 0, 65536};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: the reset bounds first, then two other shapes, edges of each
        for (int k = 0; k < 3; k++)
        begin
            if (k > 0)
                load_bounds(bounds[k][0], bounds[k][1], bounds[k][2], bounds[k][3]);
            a12 = cur[0] + cur[2];
            b12 = cur[1] + cur[3];
            s1  = cur[0] + cur[3];
            s2  = cur[2] + cur[1];
            pts = '{-2147483648, 2147483647, a12, a12 + 1, s1, s2, s2 + 1,
                    b12 - 1, b12, (a12 + b12) / 2};
            for (int i = 0; i < 10; i++)
                if (k == 0 || i >= 2)
                    send_point(clamp32(pts[i]), (i % 2 == 0) ? 1'b0 : MODE_CDF);
        end
        // directed tiny ranges, full span and invalid ranges
        for (int k = 3; k < 7; k++)
        begin
            load_bounds(bounds[k][0], bounds[k][1], bounds[k][2], bounds[k][3]);
            send_point(1, 1'b0);
            send_point(2, MODE_CDF);
        end

        // random: a new bound set every 150 items, idling off for a stretch
        idle_on = 1'b1;
        while (sent < 1700)
        begin
            setsel = $urandom_range(NSETS + 3);
            if (setsel < NSETS)
                load_bounds(bounds[setsel][0], bounds[setsel][1],
                            bounds[setsel][2], bounds[setsel][3]);
            else
            begin
                a12 = longint'(signed'($urandom));
                s1  = longint'(signed'($urandom));
                a12 = a12 >>> $urandom_range(20);
                s1  = s1 >>> $urandom_range(20);
                load_bounds(a12, clamp32(a12 + $urandom_range(1 << 20, 1)),
                            s1, clamp32(s1 + $urandom_range(1 << 22, 0)));
            end
            idle_on = !(sent > 700 && sent < 1000);
            for (int i = 0; i < 150; i++)
                send_point(pick_point(), $urandom_range(1));
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("sent %0d points over many bound sets, density and distribution modes", sent);
        $display("checked %0d results in %0d cycles", checked, cycles);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/usp_pkg.sv
hw/rtl/usp_prep.sv
hw/rtl/usp_div_cell.sv
hw/rtl/uniform_sum_pdf_cdf_unit.sv
tb/sv/uniform_sum_checker.sv
tb/sv/tb_uniform_sum_pdf_cdf_unit.sv
